FILE: rtl/quad_rate_pid_mixer_unit_macros.svh
// Assertion macros for the checker file of the quad rate PID mixer.
`ifndef QUAD_RATE_PID_MIXER_UNIT_MACROS_SVH
`define QUAD_RATE_PID_MIXER_UNIT_MACROS_SVH

// Concurrent assertion, checked off while reset is high.
`define QRPM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion, checked through reset as well.
`define QRPM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/qrpm_pkg.sv
// Package of the quad rate PID mixer: word types, lane control, constants, dead band.
package qrpm_pkg;

  localparam int RC_W       = 12;
  localparam int RATE_W     = 16;
  localparam int GAIN_W     = 18;
  localparam int LIM_W      = 10;
  localparam int MOTOR_W    = 11;
  localparam int DB_W       = 13;
  localparam int SP_W       = 21;
  localparam int ST_W       = 24;
  localparam int INT_W      = 16;
  localparam int PID_W      = 19;
  localparam int THR_W      = 11;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 18;

  localparam int DB_LOW    = 1492;
  localparam int DB_HIGH   = 1508;
  localparam int YAW_ON    = 1050;
  localparam int THR_MAX   = 1800;
  localparam int MOTOR_MIN = 1100;
  localparam int MOTOR_MAX = 2000;
  localparam int I_LIMIT   = 25600;

  // floor(x/3) = (x*RECIP3) >> 22, exact for x < 2^21
  localparam int RECIP3     = 1398102;
  localparam int RECIP3_SH  = 22;
  // floor(x/10) = (x*RECIP10) >> 30, exact for x < 2^27
  localparam int RECIP10    = 107374183;
  localparam int RECIP10_SH = 30;

  localparam logic [CFG_IDX_W-1:0] REG_KP_RP  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_RP  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_RP  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KP_YAW = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KI_YAW = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KD_YAW = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIM_RP = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LIM_YAW = 4'd7;

  typedef struct packed {
    logic [RC_W-1:0]          rc_roll;
    logic [RC_W-1:0]          rc_pitch;
    logic [RC_W-1:0]          rc_throttle;
    logic [RC_W-1:0]          rc_yaw;
    logic signed [RATE_W-1:0] rate_roll;
    logic signed [RATE_W-1:0] rate_pitch;
    logic signed [RATE_W-1:0] rate_yaw;
    logic signed [RATE_W-1:0] level_roll;
    logic signed [RATE_W-1:0] level_pitch;
  } sensor_t;

  typedef struct packed {
    logic [MOTOR_W-1:0] motor_front_right;
    logic [MOTOR_W-1:0] motor_rear_right;
    logic [MOTOR_W-1:0] motor_rear_left;
    logic [MOTOR_W-1:0] motor_front_left;
  } motor_t;

  // Step strobes broadcast from the sequencer to every lane.
  typedef struct packed {
    logic load;
    logic mul;
    logic err;
    logic gmul;
    logic integ;
    logic outp;
  } lane_ctl_t;

  // Stick dead band, closed between DB_LOW and DB_HIGH.
  function automatic logic signed [DB_W-1:0] dead_band(input logic [RC_W-1:0] r);
    logic signed [DB_W:0] rs;
    logic signed [DB_W:0] d;
    rs = $signed({2'b00, r});
    if (rs > (DB_W+1)'(DB_HIGH)) begin
      d = rs - (DB_W+1)'(DB_HIGH);
    end else if (rs < (DB_W+1)'(DB_LOW)) begin
      d = rs - (DB_W+1)'(DB_LOW);
    end else begin
      d = '0;
    end
    return DB_W'(d);
  endfunction

endpackage

FILE: rtl/qrpm_setpoint.sv
// Roll/pitch setpoint: dead band minus level correction, divided by 3 via reciprocal.
module qrpm_setpoint (
  input  logic                                clk,
  input  qrpm_pkg::lane_ctl_t                 ctl,
  input  logic [qrpm_pkg::RC_W-1:0]           rc,
  input  logic signed [qrpm_pkg::RATE_W-1:0]  level,
  output logic signed [qrpm_pkg::SP_W-1:0]    sp
);
  import qrpm_pkg::*;

  localparam int X_W    = 22;
  localparam int MAG_W  = 21;
  localparam int R3_W   = $clog2(RECIP3 + 1);
  localparam int PROD_W = MAG_W + R3_W;
  localparam int Q_W    = PROD_W - RECIP3_SH;

  logic signed [X_W-1:0] x;
  logic [MAG_W-1:0]      x_mag;
  logic [MAG_W-1:0]      mag;
  logic                  neg;
  logic [PROD_W-1:0]     prod;
  logic [Q_W-1:0]        q;

  always_comb begin
    x     = (X_W'(dead_band(rc)) <<< 8) - (X_W'(level) <<< 4);
    x_mag = x[X_W-1] ? MAG_W'(-x) : MAG_W'(x);
    q     = prod[PROD_W-1:RECIP3_SH];
    sp    = neg ? -SP_W'(q) : SP_W'(q);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mag <= x_mag;
      neg <= x[X_W-1];
    end
    if (ctl.mul) begin
      prod <= mag * R3_W'(RECIP3);
    end
  end

endmodule

FILE: rtl/qrpm_lane.sv
// One axis lane: gyro smoothing, error, PID with clamped integrator and output.
module qrpm_lane #(
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  qrpm_pkg::lane_ctl_t                 ctl,
  input  logic signed [qrpm_pkg::RATE_W-1:0]  rate,
  input  logic signed [qrpm_pkg::SP_W-1:0]    sp,
  input  logic [qrpm_pkg::GAIN_W-1:0]         kp,
  input  logic [qrpm_pkg::GAIN_W-1:0]         ki,
  input  logic [qrpm_pkg::GAIN_W-1:0]         kd,
  input  logic [qrpm_pkg::LIM_W-1:0]          limit,
  output logic signed [qrpm_pkg::PID_W-1:0]   pid_out
);
  import qrpm_pkg::*;

  localparam int Y_W     = 27;
  localparam int YMAG_W  = 26;
  localparam int R10_W   = $clog2(RECIP10 + 1);
  localparam int YPROD_W = YMAG_W + R10_W;
  localparam int Q10_W   = YPROD_W - RECIP10_SH;
  localparam int DIFF_W  = ST_W + 1;
  localparam int PE_W    = GAIN_W + 1 + ST_W;
  localparam int PD_W    = GAIN_W + 1 + DIFF_W;
  localparam int PROD_W  = PD_W;
  localparam int ISUM_W  = PROD_W + 1;
  localparam int OSUM_W  = PROD_W + 2;
  localparam int ROUND   = (1 << GAIN_FRAC_BITS) - 1;

  localparam logic signed [ISUM_W-1:0] I_HI = ISUM_W'(I_LIMIT);
  localparam logic signed [ISUM_W-1:0] I_LO = -ISUM_W'(I_LIMIT);

  // persistent per-axis state
  logic signed [ST_W-1:0]  smoothed;
  logic signed [INT_W-1:0] integ;
  logic signed [ST_W-1:0]  prev_err;

  logic [YMAG_W-1:0]       y_mag_r;
  logic                    y_neg;
  logic [YPROD_W-1:0]      y_prod;
  logic signed [ST_W-1:0]  err;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PE_W-1:0]  p_kp;
  logic signed [PE_W-1:0]  p_ki;
  logic signed [PD_W-1:0]  p_kd;
  logic signed [PROD_W-1:0] t_kp;
  logic signed [PROD_W-1:0] t_kd;

  logic signed [Y_W-1:0]    y;
  logic [YMAG_W-1:0]        y_mag;
  logic [Q10_W-1:0]         q10;
  logic signed [ST_W-1:0]   sm_next;
  logic signed [ST_W-1:0]   err_next;
  logic signed [DIFF_W-1:0] diff_next;
  logic signed [PROD_W-1:0] t_ki;
  logic signed [ISUM_W-1:0] isum;
  logic signed [INT_W-1:0]  integ_next;
  logic signed [OSUM_W-1:0] osum;
  logic signed [OSUM_W-1:0] lim;
  logic signed [PID_W-1:0]  pid_next;

  // gain product over 2^GAIN_FRAC_BITS, truncated toward zero
  function automatic logic signed [PROD_W-1:0] gscale(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] bias;
    bias = p[PROD_W-1] ? PROD_W'(ROUND) : '0;
    return (p + bias) >>> GAIN_FRAC_BITS;
  endfunction

  always_comb begin
    // 7*old + 48*rate
    y = (Y_W'(smoothed) <<< 3) - Y_W'(smoothed) + (Y_W'(rate) <<< 5) + (Y_W'(rate) <<< 4);
    y_mag = y[Y_W-1] ? YMAG_W'(-y) : YMAG_W'(y);
    q10 = y_prod[YPROD_W-1:RECIP10_SH];
    sm_next = y_neg ? -ST_W'(q10) : ST_W'(q10);
    err_next = sm_next - ST_W'(sp);
    diff_next = DIFF_W'(err_next) - DIFF_W'(prev_err);

    t_ki = gscale(PROD_W'(p_ki));
    isum = ISUM_W'(integ) + ISUM_W'(t_ki);
    if (isum > I_HI) begin
      integ_next = INT_W'(I_HI);
    end else if (isum < I_LO) begin
      integ_next = INT_W'(I_LO);
    end else begin
      integ_next = INT_W'(isum);
    end

    osum = OSUM_W'(t_kp) + OSUM_W'(integ) + OSUM_W'(t_kd);
    lim  = OSUM_W'({limit, 8'b0});
    if (osum > lim) begin
      pid_next = PID_W'(lim);
    end else if (osum < -lim) begin
      pid_next = PID_W'(-lim);
    end else begin
      pid_next = PID_W'(osum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed <= '0;
      integ    <= '0;
      prev_err <= '0;
    end else begin
      if (ctl.err) begin
        smoothed <= sm_next;
        prev_err <= err_next;
      end
      if (ctl.integ) begin
        integ <= integ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      y_mag_r <= y_mag;
      y_neg   <= y[Y_W-1];
    end
    if (ctl.mul) begin
      y_prod <= y_mag_r * R10_W'(RECIP10);
    end
    if (ctl.err) begin
      err  <= err_next;
      diff <= diff_next;
    end
    if (ctl.gmul) begin
      p_kp <= $signed({1'b0, kp}) * err;
      p_ki <= $signed({1'b0, ki}) * err;
      p_kd <= $signed({1'b0, kd}) * diff;
    end
    if (ctl.integ) begin
      t_kp <= gscale(PROD_W'(p_kp));
      t_kd <= gscale(p_kd);
    end
    if (ctl.outp) begin
      pid_out <= pid_next;
    end
  end

endmodule

FILE: rtl/qrpm_mixer.sv
// X-frame mixer: throttle plus PID outputs into four clamped motor pulses.
module qrpm_mixer (
  input  logic                               clk,
  input  logic                               load,
  input  logic [qrpm_pkg::THR_W-1:0]         thr,
  input  logic signed [qrpm_pkg::PID_W-1:0]  pr,
  input  logic signed [qrpm_pkg::PID_W-1:0]  pp,
  input  logic signed [qrpm_pkg::PID_W-1:0]  py,
  output qrpm_pkg::motor_t                   motor
);
  import qrpm_pkg::*;

  localparam int MIX_W = 23;
  localparam int US_W  = MIX_W - 8;

  logic signed [MIX_W-1:0] base;
  logic signed [MIX_W-1:0] r;
  logic signed [MIX_W-1:0] p;
  logic signed [MIX_W-1:0] w;
  motor_t                  motor_next;

  // drop the fraction, then clamp; negatives land on the floor either way
  function automatic logic [MOTOR_W-1:0] pulse(input logic signed [MIX_W-1:0] s);
    logic signed [US_W-1:0] us;
    us = $signed(s[MIX_W-1:8]);
    if (us < US_W'(MOTOR_MIN)) begin
      return MOTOR_W'(MOTOR_MIN);
    end else if (us > US_W'(MOTOR_MAX)) begin
      return MOTOR_W'(MOTOR_MAX);
    end else begin
      return MOTOR_W'(us);
    end
  endfunction

  always_comb begin
    base = MIX_W'({thr, 8'b0});
    r    = MIX_W'(pr);
    p    = MIX_W'(pp);
    w    = MIX_W'(py);
    motor_next.motor_front_right = pulse(base + p + r + w);
    motor_next.motor_rear_right  = pulse(base + p - r - w);
    motor_next.motor_rear_left   = pulse(base - p - r + w);
    motor_next.motor_front_left  = pulse(base - p + r - w);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      motor <= motor_next;
    end
  end

endmodule

FILE: rtl/quad_rate_pid_mixer_unit.sv
// Quad rate PID mixer top level: config registers, sequencer, three axis lanes, mixer.
//
// One sensor word is one control tick: four stick pulses, three gyro rates and two
// level corrections go in, four motor pulses (1100..2000 us) come out as one word.
// Each word runs through the load cycle, the reciprocal multiply (divide by 3 for
// setpoints, by 10 for smoothing), the error step, the gain multiply, the integrator
// step, the output clamp, then the mix into the output register, where motor_valid
// rises. That six-step lane sequence plus the mix ends before the next word can be
// taken; the next word is taken while the motor word still waits, and the sequencer
// stalls in the mix step only if the waiting motor word is not yet taken.
// Roll, pitch and yaw run in three lanes side by side under common step strobes.
// Config writes land at once and are meant for idle periods; unknown indexes are
// dropped. PID state (smoothed rate, integrator, previous error) clears on reset.
module quad_rate_pid_mixer_unit #(
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sensor_valid,
  output logic                                 sensor_ready,
  input  qrpm_pkg::sensor_t                    sensor,
  output logic                                 motor_valid,
  input  logic                                 motor_ready,
  output qrpm_pkg::motor_t                     motor,
  input  logic                                 cfg_we,
  input  logic [qrpm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qrpm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import qrpm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ERR,
    ST_GMUL,
    ST_INTEG,
    ST_OUTP,
    ST_MIX
  } state_t;

  state_t state;

  // config registers
  logic [GAIN_W-1:0] kp_rp, ki_rp, kd_rp;
  logic [GAIN_W-1:0] kp_yaw, ki_yaw, kd_yaw;
  logic [LIM_W-1:0]  lim_rp, lim_yaw;

  // values held for the whole tick
  logic [THR_W-1:0]       thr;
  logic signed [SP_W-1:0] sp_yaw;

  logic                   accept;
  logic                   motor_load;
  lane_ctl_t              ctl;
  logic signed [SP_W-1:0] sp_roll, sp_pitch;
  logic signed [SP_W-1:0] sp_yaw_next;
  logic [THR_W-1:0]       thr_next;
  logic signed [PID_W-1:0] pid_roll, pid_pitch, pid_yaw;

  assign sensor_ready = (state == ST_IDLE);
  assign accept       = sensor_valid && sensor_ready;
  assign motor_load   = (state == ST_MIX) && (!motor_valid || motor_ready);

  always_comb begin
    ctl.load  = accept;
    ctl.mul   = (state == ST_MUL);
    ctl.err   = (state == ST_ERR);
    ctl.gmul  = (state == ST_GMUL);
    ctl.integ = (state == ST_INTEG);
    ctl.outp  = (state == ST_OUTP);

    // yaw: dead band only above the low-stick threshold, no divide
    if (sensor.rc_yaw > RC_W'(YAW_ON)) begin
      sp_yaw_next = SP_W'(dead_band(sensor.rc_yaw)) <<< 8;
    end else begin
      sp_yaw_next = '0;
    end
    thr_next = (sensor.rc_throttle > RC_W'(THR_MAX)) ? THR_W'(THR_MAX)
                                                      : THR_W'(sensor.rc_throttle);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_rp   <= GAIN_W'(5325);
      ki_rp   <= GAIN_W'(164);
      kd_rp   <= GAIN_W'(73728);
      kp_yaw  <= GAIN_W'(16384);
      ki_yaw  <= GAIN_W'(82);
      kd_yaw  <= '0;
      lim_rp  <= LIM_W'(400);
      lim_yaw <= LIM_W'(400);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KP_RP:   kp_rp   <= cfg_data;
        REG_KI_RP:   ki_rp   <= cfg_data;
        REG_KD_RP:   kd_rp   <= cfg_data;
        REG_KP_YAW:  kp_yaw  <= cfg_data;
        REG_KI_YAW:  ki_yaw  <= cfg_data;
        REG_KD_YAW:  kd_yaw  <= cfg_data;
        REG_LIM_RP:  lim_rp  <= cfg_data[LIM_W-1:0];
        REG_LIM_YAW: lim_yaw <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      thr    <= thr_next;
      sp_yaw <= sp_yaw_next;
    end
  end

  // sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      motor_valid <= 1'b0;
    end else begin
      // a fresh motor word wins over the handshake draining the old one
      if (motor_load) begin
        motor_valid <= 1'b1;
      end else if (motor_ready) begin
        motor_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE:  if (accept) state <= ST_MUL;
        ST_MUL:   state <= ST_ERR;
        ST_ERR:   state <= ST_GMUL;
        ST_GMUL:  state <= ST_INTEG;
        ST_INTEG: state <= ST_OUTP;
        ST_OUTP:  state <= ST_MIX;
        ST_MIX:   if (motor_load) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  qrpm_setpoint u_sp_roll (
    .clk   (clk),
    .ctl   (ctl),
    .rc    (sensor.rc_roll),
    .level (sensor.level_roll),
    .sp    (sp_roll)
  );

  qrpm_setpoint u_sp_pitch (
    .clk   (clk),
    .ctl   (ctl),
    .rc    (sensor.rc_pitch),
    .level (sensor.level_pitch),
    .sp    (sp_pitch)
  );

  qrpm_lane #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_lane_roll (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rate    (sensor.rate_roll),
    .sp      (sp_roll),
    .kp      (kp_rp),
    .ki      (ki_rp),
    .kd      (kd_rp),
    .limit   (lim_rp),
    .pid_out (pid_roll)
  );

  qrpm_lane #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_lane_pitch (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rate    (sensor.rate_pitch),
    .sp      (sp_pitch),
    .kp      (kp_rp),
    .ki      (ki_rp),
    .kd      (kd_rp),
    .limit   (lim_rp),
    .pid_out (pid_pitch)
  );

  qrpm_lane #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_lane_yaw (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rate    (sensor.rate_yaw),
    .sp      (sp_yaw),
    .kp      (kp_yaw),
    .ki      (ki_yaw),
    .kd      (kd_yaw),
    .limit   (lim_yaw),
    .pid_out (pid_yaw)
  );

  qrpm_mixer u_mixer (
    .clk   (clk),
    .load  (motor_load),
    .thr   (thr),
    .pr    (pid_roll),
    .pp    (pid_pitch),
    .py    (pid_yaw),
    .motor (motor)
  );

endmodule

FILE: rtl/qrpm_checker.sv
// Port-level checker for the quad rate PID mixer, bound to the top level.
`include "quad_rate_pid_mixer_unit_macros.svh"

module qrpm_checker (
  input logic             clk,
  input logic             rst,
  input logic             sensor_valid,
  input logic             sensor_ready,
  input logic             motor_valid,
  input logic             motor_ready,
  input qrpm_pkg::motor_t motor
);
  import qrpm_pkg::*;

  logic       in_take;
  logic       out_stall;
  logic       motor_in_range;
  logic [1:0] take_hist;

  function automatic logic pulse_ok(input logic [MOTOR_W-1:0] us);
    return (us >= MOTOR_W'(MOTOR_MIN)) && (us <= MOTOR_W'(MOTOR_MAX));
  endfunction

  assign in_take   = sensor_valid && sensor_ready;
  assign out_stall = motor_valid && !motor_ready;
  assign motor_in_range = pulse_ok(motor.motor_front_right) && pulse_ok(motor.motor_rear_right)
                       && pulse_ok(motor.motor_rear_left) && pulse_ok(motor.motor_front_left);

  // accept history: bit 0 holds the latest accept, bit 1 the one before
  always_ff @(posedge clk) begin
    if (rst) begin
      take_hist <= '0;
    end else begin
      take_hist <= {take_hist[0], in_take};
    end
  end

  // a stalled motor word holds
  `QRPM_ASSERT(a_motor_hold, clk, rst, out_stall |=> motor_valid && $stable(motor), "held word moved")

  // every pulse offered lies within the motor range
  `QRPM_ASSERT(a_motor_range, clk, rst, motor_valid |-> motor_in_range, "motor pulse out of range")

  // reset leaves the block empty and ready
  `QRPM_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !motor_valid && sensor_ready, "busy after reset")

  // one tick at a time: busy right after a word is taken
  `QRPM_ASSERT(a_busy_after_accept, clk, rst, in_take |=> !sensor_ready, "ready after accept")

  // a new motor word never appears while either accept in take_hist is set
  `QRPM_ASSERT(a_no_early_result, clk, rst, $rose(motor_valid) |-> take_hist == 2'b00, "too early")

endmodule

bind quad_rate_pid_mixer_unit qrpm_checker u_qrpm_checker (.*);
